FILE: rtl/rrss_pkg.sv
// Shared types, widths and codes for the round-robin sleep scheduler.
package rrss_pkg;

    localparam int NUM_TASKS_DEF = 16;
    localparam int TASK_W        = 4;
    localparam int MODE_W        = 2;
    localparam int MS_W          = 16;
    localparam int SLICE_W       = 8;
    localparam int STAT_W        = 2;
    localparam int TSTAT_W       = 2;
    localparam int DIV_NUM_W     = MS_W + 1;
    localparam int DIV_CNT_W     = $clog2(DIV_NUM_W);

    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_YIELD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_ACTIVE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_IDLE_SLEEP = 2'd2;

    // Per-task state codes
    localparam logic [TSTAT_W-1:0] TS_INACTIVE = 2'd0;
    localparam logic [TSTAT_W-1:0] TS_READY    = 2'd1;
    localparam logic [TSTAT_W-1:0] TS_SLEEP    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic cap;
        logic start_do;
        logic idle_sleep;
        logic rot_wr;
        logic dsp_wr;
        logic div_start;
        logic park;
        logic tw_init;
        logic tw_upd;
        logic tw_end;
        logic tk_sl;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              run_idle;
        logic              cnt_zero;
        logic              cnt_le1;
        logic              ms_zero;
        logic              div_busy;
        logic              walk_done;
        logic              slice_le1;
        logic              out_free;
    } t_flags;

endpackage

FILE: rtl/rrss_in_if.sv
// Input item channel of the scheduler.
interface rrss_in_if;
    logic                       valid;
    logic                       ready;
    logic [rrss_pkg::MODE_W-1:0] mode;
    logic [rrss_pkg::TASK_W-1:0] task_id;
    logic [rrss_pkg::MS_W-1:0]   sleep_ms;

    modport source (output valid, output mode, output task_id, output sleep_ms, input ready);
    modport sink   (input valid, input mode, input task_id, input sleep_ms, output ready);
endinterface

FILE: rtl/rrss_out_if.sv
// Result channel of the scheduler.
interface rrss_out_if;
    logic                        valid;
    logic                        ready;
    logic [rrss_pkg::TASK_W-1:0] current_task;
    logic                        idle;
    logic                        switched;
    logic [rrss_pkg::STAT_W-1:0] status;

    modport source (output valid, output current_task, output idle, output switched,
                    output status, input ready);
    modport sink   (input valid, input current_task, input idle, input switched,
                    input status, output ready);
endinterface

FILE: rtl/rrss_cfg_if.sv
// Slice length configuration write channel.
interface rrss_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rrss_pkg::SLICE_W-1:0] slice_length;

    modport source (output valid, output slice_length, input ready);
    modport sink   (input valid, input slice_length, output ready);
endinterface

FILE: rtl/rrss_div.sv
// Restoring divider, one quotient bit per cycle.
module rrss_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rrss_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [rrss_pkg::SLICE_W-1:0]    i_den,
    output logic                            o_busy,
    output logic [rrss_pkg::MS_W-1:0]       o_quo
);
    logic [rrss_pkg::DIV_NUM_W-1:0] r_quo;
    logic [rrss_pkg::SLICE_W-1:0]   r_rem;
    logic [rrss_pkg::SLICE_W-1:0]   r_den;
    logic [rrss_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic [rrss_pkg::SLICE_W:0]     trial;
    logic                           ge;
    logic [rrss_pkg::SLICE_W-1:0]   n_rem;

    // Shift in the next numerator bit and try the subtract
    always_comb begin
        trial = {r_rem, r_quo[rrss_pkg::DIV_NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? rrss_pkg::SLICE_W'(trial - {1'b0, r_den})
                   : trial[rrss_pkg::SLICE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= rrss_pkg::DIV_CNT_W'(rrss_pkg::DIV_NUM_W - 1);
        end else if (r_busy) begin
            r_busy <= (r_cnt != '0);
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[rrss_pkg::DIV_NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo[rrss_pkg::MS_W-1:0];
endmodule

FILE: rtl/rrss_dp.sv
// Scheduler datapath: ready ring, sleep list, per-task counters, result register.
module rrss_dp #(
    parameter int NUM_TASKS = rrss_pkg::NUM_TASKS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rrss_pkg::t_cmd               i_cmd,
    output rrss_pkg::t_flags             o_flags,
    input  logic [rrss_pkg::MODE_W-1:0]  i_mode,
    input  logic [rrss_pkg::TASK_W-1:0]  i_task_id,
    input  logic [rrss_pkg::MS_W-1:0]    i_sleep_ms,
    input  logic                         i_cfg_valid,
    input  logic [rrss_pkg::SLICE_W-1:0] i_cfg_slice,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [rrss_pkg::TASK_W-1:0]  o_current_task,
    output logic                         o_idle,
    output logic                         o_switched,
    output logic [rrss_pkg::STAT_W-1:0]  o_status
);
    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);
    localparam logic [CNT_W:0]   NUM_SUM  = (CNT_W + 1)'(NUM_TASKS);
    localparam logic [CNT_W-1:0] NUM_CNT  = CNT_W'(NUM_TASKS);

    // Scalar state
    logic [rrss_pkg::SLICE_W-1:0] r_slice_len;
    logic [rrss_pkg::MODE_W-1:0]  r_mode;
    logic [rrss_pkg::TASK_W-1:0]  r_tid;
    logic [rrss_pkg::MS_W-1:0]    r_ms;
    logic [IDX_W-1:0]             r_head;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_scount;
    logic [CNT_W-1:0]             r_i;
    logic [CNT_W-1:0]             r_kept;
    logic [rrss_pkg::TASK_W-1:0]  r_run_task;
    logic                         r_run_idle;
    logic                         r_switched;
    logic                         r_force;
    logic [rrss_pkg::STAT_W-1:0]  r_status;
    logic [rrss_pkg::TSTAT_W-1:0] r_tstat [NUM_TASKS];

    // Result register
    logic                         r_out_valid;
    logic [rrss_pkg::TASK_W-1:0]  r_out_task;
    logic                         r_out_idle;
    logic                         r_out_sw;
    logic [rrss_pkg::STAT_W-1:0]  r_out_status;

    // Memories and their registered read data
    logic [rrss_pkg::TASK_W-1:0]  m_ring  [NUM_TASKS];
    logic [rrss_pkg::TASK_W-1:0]  m_list  [NUM_TASKS];
    logic [rrss_pkg::MS_W-1:0]    m_left  [NUM_TASKS];
    logic [rrss_pkg::SLICE_W-1:0] m_slice [NUM_TASKS];
    logic [rrss_pkg::TASK_W-1:0]  r_ring_q;
    logic [rrss_pkg::TASK_W-1:0]  r_list_q;
    logic [rrss_pkg::MS_W-1:0]    r_left_q;
    logic [rrss_pkg::SLICE_W-1:0] r_slice_q;

    // Derived values
    logic [rrss_pkg::SLICE_W-1:0] eff_slice;
    logic [CNT_W:0]               tail_sum;
    logic [IDX_W-1:0]             tail;
    logic [IDX_W-1:0]             head_inc;
    logic [IDX_W-1:0]             tid_idx;
    logic [IDX_W-1:0]             run_idx;
    logic [IDX_W-1:0]             t_idx;
    logic                         start_bad;
    logic                         left_le1;
    logic                         slice_le1;
    logic                         new_idle;
    logic                         chg;
    logic                         out_free;
    logic                         div_busy;
    logic [rrss_pkg::MS_W-1:0]    div_quo;
    logic [rrss_pkg::DIV_NUM_W-1:0] div_num;

    // Write port controls
    logic                         ring_we;
    logic [rrss_pkg::TASK_W-1:0]  ring_wdata;
    logic                         list_we;
    logic [IDX_W-1:0]             list_waddr;
    logic [rrss_pkg::TASK_W-1:0]  list_wdata;
    logic                         left_we;
    logic [IDX_W-1:0]             left_waddr;
    logic [rrss_pkg::MS_W-1:0]    left_wdata;
    logic                         slice_we;
    logic [IDX_W-1:0]             slice_waddr;
    logic [rrss_pkg::SLICE_W-1:0] slice_wdata;
    logic                         tstat_we;
    logic [IDX_W-1:0]             tstat_waddr;
    logic [rrss_pkg::TSTAT_W-1:0] tstat_wdata;

    // Ring arithmetic and lookups
    always_comb begin
        eff_slice = (r_slice_len == '0) ? rrss_pkg::SLICE_W'(1) : r_slice_len;
        tail_sum  = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_count);
        tail      = (tail_sum >= NUM_SUM) ? IDX_W'(tail_sum - NUM_SUM) : IDX_W'(tail_sum);
        head_inc  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
        tid_idx   = IDX_W'(r_tid);
        run_idx   = IDX_W'(r_run_task);
        t_idx     = IDX_W'(r_list_q);
        start_bad = (int'(r_tid) >= NUM_TASKS) || (r_tstat[tid_idx] != rrss_pkg::TS_INACTIVE);
        left_le1  = r_left_q <= rrss_pkg::MS_W'(1);
        slice_le1 = r_slice_q <= rrss_pkg::SLICE_W'(1);
        new_idle  = (r_count == '0);
        chg       = (r_run_idle != new_idle) || (!new_idle && (r_run_task != r_ring_q));
        out_free  = !r_out_valid || i_out_ready;
        div_num   = {1'b0, r_ms} + rrss_pkg::DIV_NUM_W'(eff_slice) - 1'b1;
    end

    // Write port selection
    always_comb begin
        ring_we     = 1'b0;
        ring_wdata  = r_ring_q;
        list_we     = 1'b0;
        list_waddr  = r_kept[IDX_W-1:0];
        list_wdata  = r_list_q;
        left_we     = 1'b0;
        left_waddr  = t_idx;
        left_wdata  = left_le1 ? '0 : r_left_q - 1'b1;
        slice_we    = 1'b0;
        slice_waddr = run_idx;
        slice_wdata = slice_le1 ? eff_slice : r_slice_q - 1'b1;
        tstat_we    = 1'b0;
        tstat_waddr = t_idx;
        tstat_wdata = rrss_pkg::TS_READY;
        if (i_cmd.start_do && !start_bad) begin
            ring_we     = 1'b1;
            ring_wdata  = r_tid;
            slice_we    = 1'b1;
            slice_waddr = tid_idx;
            slice_wdata = eff_slice;
            tstat_we    = 1'b1;
            tstat_waddr = tid_idx;
        end
        if (i_cmd.rot_wr) begin
            ring_we = 1'b1;
        end
        if (i_cmd.tw_upd) begin
            left_we = 1'b1;
            if (left_le1) begin
                ring_we    = 1'b1;
                ring_wdata = r_list_q;
                tstat_we   = 1'b1;
            end else begin
                list_we = 1'b1;
            end
        end
        if (i_cmd.tk_sl) begin
            slice_we = 1'b1;
        end
        if (i_cmd.park) begin
            list_we     = (r_scount < NUM_CNT);
            list_waddr  = r_scount[IDX_W-1:0];
            list_wdata  = r_run_task;
            left_we     = 1'b1;
            left_waddr  = run_idx;
            left_wdata  = div_quo;
            tstat_we    = 1'b1;
            tstat_waddr = run_idx;
            tstat_wdata = rrss_pkg::TS_SLEEP;
        end
    end

    // Memories: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (ring_we)  m_ring[tail]         <= ring_wdata;
        if (list_we)  m_list[list_waddr]   <= list_wdata;
        if (left_we)  m_left[left_waddr]   <= left_wdata;
        if (slice_we) m_slice[slice_waddr] <= slice_wdata;
        r_ring_q  <= m_ring[r_head];
        r_list_q  <= m_list[r_i[IDX_W-1:0]];
        r_left_q  <= m_left[t_idx];
        r_slice_q <= m_slice[run_idx];
    end

    // Task state flags, cleared to inactive at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TASKS; k++) begin
                r_tstat[k] <= rrss_pkg::TS_INACTIVE;
            end
        end else if (tstat_we) begin
            r_tstat[tstat_waddr] <= tstat_wdata;
        end
    end

    // Captured item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_mode <= i_mode;
            r_tid  <= i_task_id;
            r_ms   <= i_sleep_ms;
        end
    end

    // Scheduler control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_len <= rrss_pkg::SLICE_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_scount    <= '0;
            r_i         <= '0;
            r_kept      <= '0;
            r_run_task  <= '0;
            r_run_idle  <= 1'b1;
            r_switched  <= 1'b0;
            r_force     <= 1'b0;
            r_status    <= rrss_pkg::ST_OK;
        end else begin
            if (i_cfg_valid) begin
                r_slice_len <= i_cfg_slice;
            end
            if (i_cmd.cap) begin
                r_switched <= 1'b0;
                r_force    <= 1'b0;
                r_status   <= rrss_pkg::ST_OK;
            end
            if (i_cmd.start_do) begin
                if (start_bad) begin
                    r_status <= rrss_pkg::ST_ACTIVE;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.idle_sleep) begin
                r_status <= rrss_pkg::ST_IDLE_SLEEP;
            end
            if (i_cmd.rot_wr) begin
                r_head <= head_inc;
            end
            if (i_cmd.dsp_wr) begin
                r_run_idle <= new_idle;
                if (!new_idle) begin
                    r_run_task <= r_ring_q;
                end
                r_switched <= chg || r_force;
            end
            if (i_cmd.park) begin
                r_head  <= head_inc;
                r_count <= r_count - 1'b1;
                r_force <= 1'b1;
                if (r_scount < NUM_CNT) begin
                    r_scount <= r_scount + 1'b1;
                end
            end
            if (i_cmd.tw_init) begin
                r_i    <= '0;
                r_kept <= '0;
            end
            if (i_cmd.tw_upd) begin
                r_i <= r_i + 1'b1;
                if (left_le1) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_kept <= r_kept + 1'b1;
                end
            end
            if (i_cmd.tw_end) begin
                r_scount <= r_kept;
            end
        end
    end

    // Result register: load when free, drop on handoff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_task   <= r_run_idle ? '0 : r_run_task;
            r_out_idle   <= r_run_idle;
            r_out_sw     <= r_switched;
            r_out_status <= r_status;
        end
    end

    rrss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (eff_slice),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // Status toward the controller
    always_comb begin
        o_flags.mode      = r_mode;
        o_flags.run_idle  = r_run_idle;
        o_flags.cnt_zero  = (r_count == '0);
        o_flags.cnt_le1   = (r_count <= CNT_W'(1));
        o_flags.ms_zero   = (r_ms == '0);
        o_flags.div_busy  = div_busy;
        o_flags.walk_done = (r_i == r_scount);
        o_flags.slice_le1 = slice_le1;
        o_flags.out_free  = out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_current_task = r_out_task;
    assign o_idle         = r_out_idle;
    assign o_switched     = r_out_sw;
    assign o_status       = r_out_status;
endmodule

FILE: rtl/rrss_ctrl.sv
// Scheduler sequencer: steps each transaction through the datapath.
module rrss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rrss_pkg::t_flags i_flags,
    output rrss_pkg::t_cmd   o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_YCHK   = 4'd3;
    localparam logic [3:0] S_ROT_RD = 4'd4;
    localparam logic [3:0] S_ROT_WR = 4'd5;
    localparam logic [3:0] S_DSP_RD = 4'd6;
    localparam logic [3:0] S_DSP_WR = 4'd7;
    localparam logic [3:0] S_SLP_WT = 4'd8;
    localparam logic [3:0] S_TW_CHK = 4'd9;
    localparam logic [3:0] S_TW_LT  = 4'd10;
    localparam logic [3:0] S_TW_UPD = 4'd11;
    localparam logic [3:0] S_TK_SL  = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_flags.mode)
                    rrss_pkg::MODE_START: n_state = S_START;
                    rrss_pkg::MODE_TICK: begin
                        o_cmd.tw_init = 1'b1;
                        n_state       = S_TW_CHK;
                    end
                    rrss_pkg::MODE_YIELD: n_state = S_YCHK;
                    default: begin
                        priority if (i_flags.run_idle) begin
                            o_cmd.idle_sleep = 1'b1;
                            n_state          = S_DONE;
                        end else if (i_flags.ms_zero) begin
                            n_state = S_YCHK;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_SLP_WT;
                        end
                    end
                endcase
            end
            S_START: begin
                o_cmd.start_do = 1'b1;
                n_state        = S_DONE;
            end
            S_YCHK: begin
                n_state = (i_flags.run_idle || i_flags.cnt_le1) ? S_DONE : S_ROT_RD;
            end
            S_ROT_RD: n_state = S_ROT_WR;
            S_ROT_WR: begin
                o_cmd.rot_wr = 1'b1;
                n_state      = S_DSP_RD;
            end
            S_DSP_RD: n_state = S_DSP_WR;
            S_DSP_WR: begin
                o_cmd.dsp_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_SLP_WT: begin
                if (!i_flags.div_busy) begin
                    o_cmd.park = 1'b1;
                    n_state    = S_DSP_RD;
                end
            end
            S_TW_CHK: begin
                if (i_flags.walk_done) begin
                    o_cmd.tw_end = 1'b1;
                    priority if (!i_flags.run_idle) begin
                        n_state = S_TK_SL;
                    end else if (i_flags.cnt_zero) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DSP_RD;
                    end
                end else begin
                    n_state = S_TW_LT;
                end
            end
            S_TW_LT: n_state = S_TW_UPD;
            S_TW_UPD: begin
                o_cmd.tw_upd = 1'b1;
                n_state      = S_TW_CHK;
            end
            S_TK_SL: begin
                o_cmd.tk_sl = 1'b1;
                n_state     = i_flags.slice_le1 ? S_ROT_RD : S_DONE;
            end
            S_DONE: begin
                if (i_flags.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

FILE: rtl/round_robin_sleep_scheduler.sv
// Round-robin task scheduler with sleeping tasks: top level.
// One transaction at a time; the input is not ready again until the result is loaded.
// Sleep waits on the bit-serial divider, tick walks the sleep list task by task, and
// the memories behind every step have registered reads.
// Synchronous active-low reset empties the ready ring and sleep list, marks all
// tasks inactive, runs the idle task and sets the slice length to 10.
module round_robin_sleep_scheduler #(
    parameter int NUM_TASKS = rrss_pkg::NUM_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrss_in_if.sink     i_in,
    rrss_out_if.source  o_out,
    rrss_cfg_if.sink    i_cfg
);
    rrss_pkg::t_cmd   w_cmd;
    rrss_pkg::t_flags w_flags;
    logic             w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    rrss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_flags    (w_flags),
        .o_cmd      (w_cmd)
    );

    rrss_dp #(
        .NUM_TASKS (NUM_TASKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_flags        (w_flags),
        .i_mode         (i_in.mode),
        .i_task_id      (i_in.task_id),
        .i_sleep_ms     (i_in.sleep_ms),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_slice    (i_cfg.slice_length),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_current_task (o_out.current_task),
        .o_idle         (o_out.idle),
        .o_switched     (o_out.switched),
        .o_status       (o_out.status)
    );

`ifndef NO_ASSERTIONS
    // An idle result names no task
    a_idle_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.idle |-> o_out.current_task == '0)
        else $error("idle result carries a task id");

    // An ignored sleep never switches
    a_sleep_noswitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == rrss_pkg::ST_IDLE_SLEEP) |-> !o_out.switched)
        else $error("ignored sleep reported a switch");

    // Only one transaction in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken while a transaction is in flight");
`endif
endmodule
